/* rtl/knn_pkg.sv */
// Shared types and constants for the k-nearest-neighbor selector.
// Used by knn_dist, the selector top and the testbench; no dependencies.
package knn_pkg;

  localparam int MAX_DIMS   = 4;
  localparam int MAX_K      = 16;
  localparam int COORD_BITS = 16;
  localparam int ID_BITS    = 16;
  localparam int DIST_BITS  = 34;
  localparam int OUT_ID_BITS = 16;
  localparam int K_BITS     = $clog2(MAX_K + 1);
  localparam int POS_BITS   = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int DIM_BITS   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int DCFG_BITS  = 3;
  localparam int CFG_BITS   = 5;
  localparam int ENTRY_BITS = DIST_BITS + ID_BITS;

  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_CAND  = 2'd1;
  localparam logic [1:0] MODE_DRAIN = 2'd2;
  localparam logic [1:0] MODE_NOP   = 2'd3;

  localparam logic [1:0] MET_EUCLID = 2'd0;
  localparam logic [1:0] MET_MANH   = 2'd1;
  localparam logic [1:0] MET_CHEB   = 2'd2;

  localparam logic [1:0] REG_METRIC = 2'd0;
  localparam logic [1:0] REG_K      = 2'd1;
  localparam logic [1:0] REG_DIMS   = 2'd2;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic [1:0]    mode;
    logic [15:0]   point_id;
    logic [15:0]   coord_0;
    logic [15:0]   coord_1;
    logic [15:0]   coord_2;
    logic [15:0]   coord_3;
  } in_item_t;

  typedef struct packed {
    logic [15:0]          neighbor_id;
    logic [DIST_BITS-1:0] distance;
    logic                 is_last;
    logic                 empty_res;
  } out_item_t;

  typedef struct packed {
    logic [DIST_BITS-1:0] dval;
    logic [ID_BITS-1:0]   id;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE, S_DIST, S_INS_RD, S_INS_CMP, S_FULL_RD, S_FULL_CMP, S_DRAIN_RD, S_DRAIN_LD
  } state_t;

endpackage

/* rtl/knn_ram.sv */
// Generic one-write, one-read synchronous RAM with registered read data.
// No dependencies.
module knn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/knn_dist.sv */
// Iterative distance unit: one dimension per cycle, squared Euclidean,
// Manhattan or Chebyshev. Depends on knn_pkg.
module knn_dist (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [1:0]                    metric,
  input  logic [knn_pkg::DCFG_BITS-1:0] dims,
  input  knn_pkg::coord_t               cand [knn_pkg::MAX_DIMS],
  input  knn_pkg::coord_t               query [knn_pkg::MAX_DIMS],
  output logic                          done,
  output logic [knn_pkg::DIST_BITS-1:0] dist_sum
);

  logic                          busy;
  logic [knn_pkg::DIM_BITS-1:0]  d;
  logic [knn_pkg::DIM_BITS-1:0]  last;
  logic [knn_pkg::DCFG_BITS-1:0] nd;
  knn_pkg::coord_t               a, b, diff;
  logic [2*knn_pkg::COORD_BITS-1:0] sq;
  logic [knn_pkg::DIST_BITS-1:0] acc_next;

  always_comb begin
    if (dims == '0) nd = knn_pkg::DCFG_BITS'(1);
    else if (dims > knn_pkg::DCFG_BITS'(knn_pkg::MAX_DIMS))
      nd = knn_pkg::DCFG_BITS'(knn_pkg::MAX_DIMS);
    else nd = dims;
    last = knn_pkg::DIM_BITS'(nd - knn_pkg::DCFG_BITS'(1));
    a    = cand[d];
    b    = query[d];
    diff = (a > b) ? a - b : b - a;
    sq   = diff * diff;
    case (metric)
      knn_pkg::MET_EUCLID: acc_next = dist_sum + knn_pkg::DIST_BITS'(sq);
      knn_pkg::MET_MANH:   acc_next = dist_sum + knn_pkg::DIST_BITS'(diff);
      default: acc_next = (knn_pkg::DIST_BITS'(diff) > dist_sum) ?
                          knn_pkg::DIST_BITS'(diff) : dist_sum;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      d    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        d        <= '0;
        dist_sum <= '0;
      end else if (busy) begin
        dist_sum <= acc_next;
        d        <= d + knn_pkg::DIM_BITS'(1);
        if (d == last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/knn_top_k_selector_top.sv */
// Top level of the k-nearest-neighbor selector: control sequencer and
// neighbor store. Depends on knn_pkg, knn_ram and knn_dist.
//
// Usage:
//   Input channel (in_valid/in_stall, in_item): mode 0 loads the query point
//   and id and empties the store; mode 1 offers a candidate; mode 2 drains.
//   Output channel (out_valid/out_stall, out_item): the drained neighbors in
//   ascending (distance, id) order, is_last on the final one; an empty store
//   gives one item with empty_res set. Mode 3 is dropped.
//   Configuration (cfg_we, cfg_idx, cfg_wdata): metric, k, dims; write only
//   while the block is idle.
//   Timing: one item is worked on at a time. A query load is done in the
//   accept cycle. A candidate takes the accept cycle, the distance loop, a
//   read and a compare for each stored entry it moves past in the store (at
//   most k - 1) and a write, with a read and compare of the last entry first
//   when the store is full. A drain reads each result from the store, then
//   loads it into the output register. in_stall is high while an item
//   is at work. Reset clears configuration to metric 0, k 2, dims 2, the
//   query to zero and the fill count to zero; the store is not cleared.
//   A stalled output holds its item; the drain waits until it is taken.
module knn_top_k_selector_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  knn_pkg::in_item_t             in_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  output knn_pkg::out_item_t            out_item,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_idx,
  input  logic [knn_pkg::CFG_BITS-1:0]  cfg_wdata
);

  knn_pkg::state_t state, state_next;
  logic [1:0]                    metric;
  logic [knn_pkg::K_BITS-1:0]    kcfg, k, fill, fill_next, nout, nout_next, rcnt, rcnt_next;
  logic [knn_pkg::DCFG_BITS-1:0] dims;
  logic [knn_pkg::POS_BITS-1:0]  pos, pos_next;
  knn_pkg::coord_t               qp [knn_pkg::MAX_DIMS];
  knn_pkg::coord_t               cp [knn_pkg::MAX_DIMS];
  logic [knn_pkg::ID_BITS-1:0]   qid, cand_id;
  logic [knn_pkg::DIST_BITS-1:0] cand_dist, dist_sum;
  logic                          dist_done, dist_start;
  logic                          accept, out_free, out_load, ram_we;
  knn_pkg::out_item_t            out_next;
  logic [knn_pkg::POS_BITS-1:0]  waddr, raddr;
  knn_pkg::entry_t               wdata, rdata, cand;
  logic [knn_pkg::K_BITS-1:0]    fill_c;
  logic                          less;

  knn_ram #(.WIDTH(knn_pkg::ENTRY_BITS), .DEPTH(knn_pkg::MAX_K)) u_ram (
    .clk(clk), .we(ram_we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  knn_dist u_dist (
    .clk(clk), .rst(rst), .start(dist_start), .metric(metric), .dims(dims),
    .cand(cp), .query(qp), .done(dist_done), .dist_sum(dist_sum)
  );

  assign in_stall = (state != knn_pkg::S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign cand     = '{dval: cand_dist, id: cand_id};
  assign less     = (cand_dist < rdata.dval) ||
                    ((cand_dist == rdata.dval) && (cand_id < rdata.id));

  always_comb begin
    if (kcfg == '0) k = knn_pkg::K_BITS'(1);
    else if (kcfg > knn_pkg::K_BITS'(knn_pkg::MAX_K)) k = knn_pkg::K_BITS'(knn_pkg::MAX_K);
    else k = kcfg;
    fill_c = (fill > k) ? k : fill;
  end

  always_comb begin
    state_next = state;
    fill_next  = fill;
    pos_next   = pos;
    nout_next  = nout;
    rcnt_next  = rcnt;
    dist_start = 1'b0;
    ram_we     = 1'b0;
    waddr      = pos;
    wdata      = cand;
    raddr      = pos - knn_pkg::POS_BITS'(1);
    out_load   = 1'b0;
    out_next   = '0;
    unique case (state)
      knn_pkg::S_IDLE: begin
        if (accept) begin
          case (in_item.mode)
            knn_pkg::MODE_LOAD: fill_next = '0;
            knn_pkg::MODE_CAND: begin
              fill_next = fill_c;
              if (in_item.point_id != qid) begin
                dist_start = 1'b1;
                state_next = knn_pkg::S_DIST;
              end
            end
            knn_pkg::MODE_DRAIN: begin
              nout_next  = fill_c;
              rcnt_next  = '0;
              state_next = knn_pkg::S_DRAIN_RD;
            end
            default: ;
          endcase
        end
      end
      knn_pkg::S_DIST: begin
        if (dist_done) begin
          if (fill < k) begin
            pos_next   = knn_pkg::POS_BITS'(fill);
            fill_next  = fill + knn_pkg::K_BITS'(1);
            state_next = knn_pkg::S_INS_RD;
          end else begin
            state_next = knn_pkg::S_FULL_RD;
          end
        end
      end
      knn_pkg::S_INS_RD: begin
        if (pos == '0) begin
          ram_we     = 1'b1;
          state_next = knn_pkg::S_IDLE;
        end else begin
          state_next = knn_pkg::S_INS_CMP;
        end
      end
      knn_pkg::S_INS_CMP: begin
        ram_we = 1'b1;
        if (less) begin
          wdata      = rdata;
          pos_next   = pos - knn_pkg::POS_BITS'(1);
          state_next = knn_pkg::S_INS_RD;
        end else begin
          state_next = knn_pkg::S_IDLE;
        end
      end
      knn_pkg::S_FULL_RD: begin
        raddr      = knn_pkg::POS_BITS'(k - knn_pkg::K_BITS'(1));
        state_next = knn_pkg::S_FULL_CMP;
      end
      knn_pkg::S_FULL_CMP: begin
        if (cand_dist < rdata.dval) begin
          pos_next   = knn_pkg::POS_BITS'(k - knn_pkg::K_BITS'(1));
          state_next = knn_pkg::S_INS_RD;
        end else begin
          state_next = knn_pkg::S_IDLE;
        end
      end
      knn_pkg::S_DRAIN_RD: begin
        raddr = knn_pkg::POS_BITS'(rcnt);
        if (out_free) begin
          if (nout == '0) begin
            out_load           = 1'b1;
            out_next.is_last   = 1'b1;
            out_next.empty_res = 1'b1;
            state_next         = knn_pkg::S_IDLE;
          end else begin
            state_next = knn_pkg::S_DRAIN_LD;
          end
        end
      end
      knn_pkg::S_DRAIN_LD: begin
        out_load             = 1'b1;
        out_next.neighbor_id = knn_pkg::OUT_ID_BITS'(rdata.id);
        out_next.distance    = rdata.dval;
        out_next.is_last     = (rcnt + knn_pkg::K_BITS'(1) == nout);
        rcnt_next            = rcnt + knn_pkg::K_BITS'(1);
        state_next           = out_next.is_last ? knn_pkg::S_IDLE : knn_pkg::S_DRAIN_RD;
      end
      default: state_next = knn_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= knn_pkg::S_IDLE;
      metric    <= 2'd0;
      kcfg      <= knn_pkg::K_BITS'(2);
      dims      <= knn_pkg::DCFG_BITS'(2);
      fill      <= '0;
      qid       <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < knn_pkg::MAX_DIMS; i++) qp[i] <= '0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      if (cfg_we) begin
        case (cfg_idx)
          knn_pkg::REG_METRIC: metric <= cfg_wdata[1:0];
          knn_pkg::REG_K:      kcfg   <= cfg_wdata[knn_pkg::K_BITS-1:0];
          knn_pkg::REG_DIMS:   dims   <= cfg_wdata[knn_pkg::DCFG_BITS-1:0];
          default: ;
        endcase
      end
      if (accept && in_item.mode == knn_pkg::MODE_LOAD) begin
        qid   <= in_item.point_id;
        qp[0] <= in_item.coord_0;
        qp[1] <= in_item.coord_1;
        qp[2] <= in_item.coord_2;
        qp[3] <= in_item.coord_3;
      end
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    pos  <= pos_next;
    nout <= nout_next;
    rcnt <= rcnt_next;
    if (out_load) out_item <= out_next;
    if (dist_done) cand_dist <= dist_sum;
    if (accept) begin
      cand_id <= in_item.point_id;
      cp[0]   <= in_item.coord_0;
      cp[1]   <= in_item.coord_1;
      cp[2]   <= in_item.coord_2;
      cp[3]   <= in_item.coord_3;
    end
  end

endmodule

/* sim/tb_knn_top_k_selector_top.sv */
// Testbench for knn_top_k_selector_top: streams queries, candidates and drains,
// predicts the kept neighbors per drain and checks every output item.
// Depends on knn_pkg and the RTL of the selector.
module tb_knn_top_k_selector_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  knn_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  knn_pkg::out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_idx = '0;
  logic [knn_pkg::CFG_BITS-1:0] cfg_wdata = '0;

  knn_top_k_selector_top dut (.*);

  always #4 clk = ~clk;

  // predictor state
  logic [1:0] met_q;
  logic [4:0] k_q;
  logic [2:0] dims_q;
  knn_pkg::coord_t qry_pt[knn_pkg::MAX_DIMS];
  logic [knn_pkg::ID_BITS-1:0] qry_id;
  knn_pkg::entry_t nbrs[knn_pkg::MAX_K];
  int fill;

  knn_pkg::in_item_t pending_items[$];
  knn_pkg::out_item_t expected_nbrs[$];
  int errors = 0;
  int idle_pct = 11;
  int quiet_cycles = 0;
  bit stim_done = 0;

  function automatic void queue_item(knn_pkg::in_item_t it);
    pending_items.insert(pending_items.size(), it);
  endfunction

  function automatic void expect_item(knn_pkg::out_item_t o);
    expected_nbrs.insert(expected_nbrs.size(), o);
  endfunction

  function automatic int k_eff();
    if (k_q < 1) return 1;
    if (k_q > knn_pkg::MAX_K) return knn_pkg::MAX_K;
    return k_q;
  endfunction

  function automatic logic [knn_pkg::DIST_BITS-1:0] dist_of(knn_pkg::in_item_t it);
    logic [knn_pkg::DIST_BITS-1:0] acc;
    logic [knn_pkg::COORD_BITS-1:0] c[knn_pkg::MAX_DIMS];
    logic [knn_pkg::COORD_BITS-1:0] diff;
    int n;
    acc = '0;
    c[0] = it.coord_0; c[1] = it.coord_1; c[2] = it.coord_2; c[3] = it.coord_3;
    n = (dims_q < 1) ? 1 : ((dims_q > knn_pkg::MAX_DIMS) ? knn_pkg::MAX_DIMS : dims_q);
    for (int d = 0; d < n; d++) begin
      diff = (c[d] > qry_pt[d]) ? c[d] - qry_pt[d] : qry_pt[d] - c[d];
      if (met_q == knn_pkg::MET_EUCLID)
        acc += knn_pkg::DIST_BITS'(diff) * knn_pkg::DIST_BITS'(diff);
      else if (met_q == knn_pkg::MET_MANH) acc += knn_pkg::DIST_BITS'(diff);
      else if (knn_pkg::DIST_BITS'(diff) > acc) acc = knn_pkg::DIST_BITS'(diff);
    end
    return acc;
  endfunction

  task automatic place_sorted(int cnt, logic [knn_pkg::DIST_BITS-1:0] dv,
                              logic [knn_pkg::ID_BITS-1:0] idv);
    int pos;
    pos = cnt;
    while (pos > 0 && (dv < nbrs[pos-1].dval ||
           (dv == nbrs[pos-1].dval && idv < nbrs[pos-1].id))) begin
      nbrs[pos] = nbrs[pos-1];
      pos--;
    end
    nbrs[pos].dval = dv;
    nbrs[pos].id = idv;
  endtask

  task automatic predict_neighbors(knn_pkg::in_item_t it);
    int k;
    int n;
    logic [knn_pkg::DIST_BITS-1:0] dv;
    knn_pkg::out_item_t o;
    k = k_eff();
    if (it.mode == knn_pkg::MODE_LOAD) begin
      qry_pt[0] = it.coord_0; qry_pt[1] = it.coord_1;
      qry_pt[2] = it.coord_2; qry_pt[3] = it.coord_3;
      qry_id = it.point_id;
      fill = 0;
    end else if (it.mode == knn_pkg::MODE_CAND) begin
      if (fill > k) fill = k;
      if (it.point_id != qry_id) begin
        dv = dist_of(it);
        if (fill < k) begin
          place_sorted(fill, dv, it.point_id);
          fill++;
        end else if (fill > 0 && dv < nbrs[fill-1].dval) begin
          place_sorted(fill - 1, dv, it.point_id);
        end
      end
    end else if (it.mode == knn_pkg::MODE_DRAIN) begin
      n = (fill < k) ? fill : k;
      if (n == 0) begin
        o = '0; o.is_last = 1'b1; o.empty_res = 1'b1;
        expect_item(o);
      end
      for (int r = 0; r < n; r++) begin
        o.neighbor_id = nbrs[r].id;
        o.distance = nbrs[r].dval;
        o.is_last = (r + 1 == n);
        o.empty_res = 1'b0;
        expect_item(o);
      end
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) predict_neighbors(in_item);
      if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
        in_item <= pending_items.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_nbrs.size() == 0) begin
          $display("%0t unexpected item: actual %p", $time, out_item);
          errors++;
        end else if (expected_nbrs[0] !== out_item) begin
          $display("%0t mismatch: expected %p actual %p", $time, expected_nbrs[0], out_item);
          errors++;
          void'(expected_nbrs.pop_front());
        end else begin
          void'(expected_nbrs.pop_front());
        end
      end
      out_stall <= ($urandom_range(99) < idle_pct);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 5000 && !stim_done) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  function automatic knn_pkg::in_item_t rand_item(logic [1:0] mode);
    knn_pkg::in_item_t it;
    it.mode = mode;
    it.point_id = 16'($urandom_range(15));
    if ($urandom_range(3) == 0) it.point_id = 16'($urandom);
    it.coord_0 = 16'($urandom); it.coord_1 = 16'($urandom);
    it.coord_2 = 16'($urandom); it.coord_3 = 16'($urandom);
    if ($urandom_range(3) == 0) it.coord_0 = $urandom_range(1) ? 16'hFFFF : 16'h0;
    return it;
  endfunction

  task automatic settle();
    while (pending_items.size() > 0 || in_valid || expected_nbrs.size() > 0)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [4:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == knn_pkg::REG_METRIC) met_q = val[1:0];
    else if (idx == knn_pkg::REG_K) k_q = val;
    else if (idx == knn_pkg::REG_DIMS) dims_q = val[2:0];
  endtask

  initial begin
    knn_pkg::in_item_t it;
    int cnt;
    met_q = knn_pkg::MET_EUCLID; k_q = 5'd2; dims_q = 3'd2; qry_id = '0; fill = 0;
    foreach (qry_pt[i]) qry_pt[i] = '0;
    foreach (nbrs[i]) nbrs[i] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    // directed: empty drain, no query loaded, self match, ties, extremes, mode 3
    queue_item(rand_item(knn_pkg::MODE_DRAIN));
    it = '0; it.mode = knn_pkg::MODE_CAND; it.point_id = 16'd0; queue_item(it);
    it.point_id = 16'd5; it.coord_0 = 16'hFFFF; it.coord_1 = 16'hFFFF;
    queue_item(it);
    it.point_id = 16'd3; queue_item(it);
    it.point_id = 16'd4; queue_item(it);
    it = '0; it.mode = knn_pkg::MODE_CAND; it.point_id = 16'hFFFF; it.coord_0 = 16'd1;
    queue_item(it);
    queue_item(rand_item(knn_pkg::MODE_DRAIN));
    queue_item(rand_item(knn_pkg::MODE_DRAIN));
    it = '1; it.mode = knn_pkg::MODE_NOP; queue_item(it);
    it = '1; it.mode = knn_pkg::MODE_LOAD; queue_item(it);
    it = '1; it.mode = knn_pkg::MODE_CAND; queue_item(it);
    queue_item(rand_item(knn_pkg::MODE_DRAIN));
    settle();
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          write_reg(knn_pkg::REG_METRIC, 5'(knn_pkg::MET_MANH));
          write_reg(knn_pkg::REG_K, 5'd16); write_reg(knn_pkg::REG_DIMS, 5'd4);
        end
        1: begin
          write_reg(knn_pkg::REG_METRIC, 5'(knn_pkg::MET_CHEB));
          write_reg(knn_pkg::REG_K, 5'd1); write_reg(knn_pkg::REG_DIMS, 5'd1);
        end
        2: begin
          write_reg(knn_pkg::REG_METRIC, 5'd3);
          write_reg(knn_pkg::REG_K, 5'd0); write_reg(knn_pkg::REG_DIMS, 5'd0);
        end
        3: begin
          write_reg(knn_pkg::REG_METRIC, 5'(knn_pkg::MET_EUCLID));
          write_reg(knn_pkg::REG_K, 5'd31); write_reg(knn_pkg::REG_DIMS, 5'd7);
        end
        4: idle_pct = 0;
        5: begin
          idle_pct = 11;
          write_reg(knn_pkg::REG_K, 5'd3); write_reg(knn_pkg::REG_DIMS, 5'd3);
        end
        default: begin
          write_reg(knn_pkg::REG_METRIC, 5'($urandom_range(3)));
          write_reg(knn_pkg::REG_K, 5'($urandom_range(31)));
          write_reg(knn_pkg::REG_DIMS, 5'($urandom_range(7)));
        end
      endcase
      if (ph != 4) queue_item(rand_item(knn_pkg::MODE_LOAD));
      cnt = $urandom_range(6, 20);
      for (int i = 0; i < cnt; i++)
        queue_item(rand_item($urandom_range(9) == 0 ? knn_pkg::MODE_NOP : knn_pkg::MODE_CAND));
      queue_item(rand_item(knn_pkg::MODE_DRAIN));
      queue_item(rand_item(knn_pkg::MODE_DRAIN));
      settle();
    end
    stim_done = 1;
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule
